[hw/rtl/shortest_path_reach_summary_assert.svh]
// Assertion macros for the shortest path reach summary block.
// Included by the top level; no other dependencies.
`ifndef SHORTEST_PATH_REACH_SUMMARY_ASSERT_SVH
`define SHORTEST_PATH_REACH_SUMMARY_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SPR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("spr assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("spr assertion failed");

`endif

[hw/rtl/spr_pkg.sv]
// Package for the shortest path reach summary block: sizes, codes, types.
// No dependencies.
`timescale 1ns / 1ps
package spr_pkg;
    localparam int MAX_NODES   = 1024;
    localparam int MAX_EDGES   = 4096;
    localparam int NODE_BITS   = 10;
    localparam int EPTR_BITS   = 13;   // edge pointer, MAX_EDGES is the empty marker
    localparam int EADDR_BITS  = 12;
    localparam int WEIGHT_BITS = 16;
    localparam int DIST_BITS   = 30;
    localparam int HEAP_CAP    = MAX_EDGES + 1;
    localparam int HEAP_BITS   = 13;
    localparam int OUT_DBITS   = 28;

    localparam logic [DIST_BITS-1:0] INF_DIST = 30'd1000000000;
    localparam logic [EPTR_BITS-1:0] NO_EDGE  = 13'(MAX_EDGES);

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;   // unused code, ignored

    typedef struct packed {
        logic [DIST_BITS-1:0] key;
        logic [NODE_BITS-1:0] node;
    } t_heap_ent;

    typedef struct packed {
        logic [NODE_BITS-1:0]   target;
        logic [WEIGHT_BITS-1:0] cost;
        logic [EPTR_BITS-1:0]   link;
    } t_edge;

    typedef enum logic [4:0] {
        ST_FCLR, ST_IDLE, ST_ADD_RD, ST_ADD_WR, ST_DCLR, ST_SEED,
        ST_POP0, ST_POP1, ST_POP2, ST_SD0, ST_SD1, ST_SD2, ST_SD3,
        ST_CHK, ST_CHK1, ST_CHK2, ST_ED0, ST_ED1, ST_ED2,
        ST_PU0, ST_PU1, ST_SUM
    } t_state;
endpackage

[hw/rtl/spr_in_if.sv]
// Input channel interface: valid/ready plus one input word.
// Depends on spr_pkg for field widths.
`timescale 1ns / 1ps
interface spr_in_if import spr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [1:0]             opcode;
    logic [NODE_BITS-1:0]   src_node;
    logic [NODE_BITS-1:0]   dst_node;
    logic [WEIGHT_BITS-1:0] weight;
    logic [NODE_BITS-1:0]   start_node;

    modport source (output valid, opcode, src_node, dst_node, weight, start_node,
                    input ready);
    modport sink   (input valid, opcode, src_node, dst_node, weight, start_node,
                    output ready);
endinterface

[hw/rtl/spr_out_if.sv]
// Result channel interface: valid/ready plus one result word.
// Depends on spr_pkg for field widths.
`timescale 1ns / 1ps
interface spr_out_if import spr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [NODE_BITS-1:0] reached_count;
    logic [OUT_DBITS-1:0] max_distance;
    logic                 edges_dropped;

    modport source (output valid, reached_count, max_distance, edges_dropped,
                    input ready);
    modport sink   (input valid, reached_count, max_distance, edges_dropped,
                    output ready);
endinterface

[hw/rtl/spr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module spr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hw/rtl/shortest_path_reach_summary.sv]
// Shortest path reach summary: top level, sequencer and the four RAMs.
// Depends on spr_pkg, spr_in_if, spr_out_if, spr_ram and the assert header.
// An add-edge word reads the node's list head, then does the write; a clear
// word runs the sweep of all list heads, and the same sweep runs after reset
// before the first word is taken. A run word sweeps the distance table to INF,
// then walks the graph with a binary min-heap held in one RAM: each pop reads
// the top and last entries and sifts down level by level, each relaxed edge
// reads the edge and the target's distance and then sifts up level by level,
// and the summary pass reads nodes 1..node_count, one a cycle. These steps are
// set by the single read port of each RAM. The result word sits in an output
// register; the next input word can be taken while it waits.
`timescale 1ns / 1ps
`include "shortest_path_reach_summary_assert.svh"
module shortest_path_reach_summary import spr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [NODE_BITS-1:0] i_cfg_data,
    spr_in_if.sink               i_in,
    spr_out_if.source            o_out
);
    t_state                 r_state, n_state;
    logic [NODE_BITS:0]     r_idx, n_idx;
    logic [EPTR_BITS-1:0]   r_stored, n_stored;
    logic                   r_ovf, n_ovf;
    logic [NODE_BITS-1:0]   r_ncount;
    logic [NODE_BITS-1:0]   r_start, n_start;
    logic [NODE_BITS-1:0]   r_src, n_src;
    logic [NODE_BITS-1:0]   r_dst, n_dst;
    logic [WEIGHT_BITS-1:0] r_w, n_w;
    logic [HEAP_BITS-1:0]   r_fill, n_fill;
    t_heap_ent              r_top, n_top;
    t_heap_ent              r_last, n_last;
    t_heap_ent              r_child, n_child;
    logic [HEAP_BITS-1:0]   r_hi, n_hi;
    logic [HEAP_BITS-1:0]   r_hc, n_hc;
    logic [EPTR_BITS-1:0]   r_e, n_e;
    t_edge                  r_edge, n_edge;
    logic [DIST_BITS-1:0]   r_newd, n_newd;
    logic                   r_pv, n_pv;
    logic [NODE_BITS-1:0]   r_pidx, n_pidx;
    logic [NODE_BITS-1:0]   r_cnt, n_cnt;
    logic [DIST_BITS-1:0]   r_max, n_max;
    logic                   r_ovalid, n_ovalid;
    logic [NODE_BITS-1:0]   r_ocnt, n_ocnt;
    logic [OUT_DBITS-1:0]   r_omax, n_omax;
    logic                   r_odrop, n_odrop;

    // RAM ports
    logic                   first_we;
    logic [NODE_BITS-1:0]   first_waddr, first_raddr;
    logic [EPTR_BITS-1:0]   first_wdata, first_rdata;
    logic                   edge_we;
    logic [EADDR_BITS-1:0]  edge_waddr, edge_raddr;
    t_edge                  edge_wdata, edge_rdata;
    logic                   best_we;
    logic [NODE_BITS-1:0]   best_waddr, best_raddr;
    logic [DIST_BITS-1:0]   best_wdata, best_rdata;
    logic                   heap_we;
    logic [HEAP_BITS-1:0]   heap_waddr, heap_raddr;
    t_heap_ent              heap_wdata, heap_rdata;

    logic                   in_acc;
    logic                   run_acc;
    logic [HEAP_BITS:0]     c_left, c_right;
    logic [DIST_BITS:0]     relax_sum;
    logic                   sum_issue;

    spr_ram #(.WIDTH(EPTR_BITS), .DEPTH(MAX_NODES)) u_first (
        .i_clk(i_clk), .i_we(first_we), .i_waddr(first_waddr), .i_wdata(first_wdata),
        .i_raddr(first_raddr), .o_rdata(first_rdata)
    );
    spr_ram #(.WIDTH($bits(t_edge)), .DEPTH(MAX_EDGES)) u_edge (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(edge_waddr), .i_wdata(edge_wdata),
        .i_raddr(edge_raddr), .o_rdata(edge_rdata)
    );
    spr_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_NODES)) u_best (
        .i_clk(i_clk), .i_we(best_we), .i_waddr(best_waddr), .i_wdata(best_wdata),
        .i_raddr(best_raddr), .o_rdata(best_rdata)
    );
    spr_ram #(.WIDTH($bits(t_heap_ent)), .DEPTH(HEAP_CAP)) u_heap (
        .i_clk(i_clk), .i_we(heap_we), .i_waddr(heap_waddr), .i_wdata(heap_wdata),
        .i_raddr(heap_raddr), .o_rdata(heap_rdata)
    );

    assign i_in.ready          = (r_state == ST_IDLE);
    assign in_acc              = i_in.valid && i_in.ready;
    assign run_acc             = in_acc && (i_in.opcode == OP_RUN);
    assign o_out.valid         = r_ovalid;
    assign o_out.reached_count = r_ocnt;
    assign o_out.max_distance  = r_omax;
    assign o_out.edges_dropped = r_odrop;

    // heap children of r_hi: 2i+1 and 2i+2
    assign c_left    = {r_hi, 1'b1};
    assign c_right   = {r_hi, 1'b0} + (HEAP_BITS+1)'(2);
    assign relax_sum = {1'b0, r_top.key} + (DIST_BITS+1)'(r_edge.cost);
    assign sum_issue = (r_idx <= {1'b0, r_ncount});

    always_comb begin
        n_state = r_state;  n_idx = r_idx;    n_stored = r_stored; n_ovf = r_ovf;
        n_start = r_start;  n_src = r_src;    n_dst = r_dst;       n_w = r_w;
        n_fill = r_fill;    n_top = r_top;    n_last = r_last;     n_child = r_child;
        n_hi = r_hi;        n_hc = r_hc;      n_e = r_e;           n_edge = r_edge;
        n_newd = r_newd;    n_pv = r_pv;      n_pidx = r_pidx;     n_cnt = r_cnt;
        n_max = r_max;      n_ocnt = r_ocnt;  n_omax = r_omax;     n_odrop = r_odrop;
        n_ovalid = r_ovalid && !o_out.ready;

        first_we = 1'b0; first_waddr = r_src; first_wdata = NO_EDGE; first_raddr = r_src;
        edge_we = 1'b0; edge_waddr = r_stored[EADDR_BITS-1:0];
        edge_wdata = '{target: r_dst, cost: r_w, link: first_rdata};
        edge_raddr = r_e[EADDR_BITS-1:0];
        best_we = 1'b0; best_waddr = r_idx[NODE_BITS-1:0]; best_wdata = INF_DIST;
        best_raddr = r_top.node;
        heap_we = 1'b0; heap_waddr = r_hi; heap_wdata = r_last; heap_raddr = '0;

        case (r_state)
            ST_FCLR: begin
                first_we    = 1'b1;
                first_waddr = r_idx[NODE_BITS-1:0];
                n_idx       = r_idx + 1'b1;
                if (r_idx[NODE_BITS-1:0] == NODE_BITS'(MAX_NODES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                n_idx = '0;
                if (in_acc) begin
                    n_src   = i_in.src_node;
                    n_dst   = i_in.dst_node;
                    n_w     = i_in.weight;
                    n_start = i_in.start_node;
                    case (i_in.opcode)
                        OP_ADD: begin
                            if (r_stored == EPTR_BITS'(MAX_EDGES)) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_state = ST_ADD_RD;
                            end
                        end
                        OP_RUN:   n_state = ST_DCLR;
                        OP_CLEAR: begin
                            n_stored = '0;
                            n_ovf    = 1'b0;
                            n_state  = ST_FCLR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ADD_RD: n_state = ST_ADD_WR;  // list head read in flight
            ST_ADD_WR: begin
                edge_we     = 1'b1;
                first_we    = 1'b1;
                first_wdata = r_stored;
                n_stored    = r_stored + 1'b1;
                n_state     = ST_IDLE;
            end
            ST_DCLR: begin
                best_we = 1'b1;
                n_idx   = r_idx + 1'b1;
                if (r_idx[NODE_BITS-1:0] == NODE_BITS'(MAX_NODES - 1)) begin
                    n_state = ST_SEED;
                end
            end
            ST_SEED: begin
                best_we    = 1'b1;
                best_waddr = r_start;
                best_wdata = '0;
                heap_we    = 1'b1;
                heap_waddr = '0;
                heap_wdata = '{key: '0, node: r_start};
                n_fill     = HEAP_BITS'(1);
                n_state    = ST_POP0;
            end
            ST_POP0: begin
                if (r_fill == '0) begin
                    n_idx   = (NODE_BITS+1)'(1);
                    n_pv    = 1'b0;
                    n_cnt   = '0;
                    n_max   = '0;
                    n_state = ST_SUM;
                end else begin
                    n_fill  = r_fill - 1'b1;
                    n_state = ST_POP1;
                end
            end
            ST_POP1: begin
                n_top      = heap_rdata;
                heap_raddr = r_fill;
                n_state    = (r_fill == '0) ? ST_CHK : ST_POP2;
            end
            ST_POP2: begin
                n_last  = heap_rdata;
                n_hi    = '0;
                n_state = ST_SD0;
            end
            ST_SD0: begin
                if (c_left >= {1'b0, r_fill}) begin
                    heap_we = 1'b1;
                    n_state = ST_CHK;
                end else begin
                    heap_raddr = c_left[HEAP_BITS-1:0];
                    n_hc       = c_left[HEAP_BITS-1:0];
                    n_state    = ST_SD1;
                end
            end
            ST_SD1: begin
                n_child = heap_rdata;
                if (c_right < {1'b0, r_fill}) begin
                    heap_raddr = c_right[HEAP_BITS-1:0];
                    n_state    = ST_SD2;
                end else begin
                    n_state = ST_SD3;
                end
            end
            ST_SD2: begin
                if (heap_rdata.key < r_child.key) begin
                    n_child = heap_rdata;
                    n_hc    = r_hc + 1'b1;
                end
                n_state = ST_SD3;
            end
            ST_SD3: begin
                heap_we = 1'b1;
                if (r_last.key <= r_child.key) begin
                    n_state = ST_CHK;
                end else begin
                    heap_wdata = r_child;
                    n_hi       = r_hc;
                    n_state    = ST_SD0;
                end
            end
            ST_CHK: n_state = ST_CHK1;  // best[top.node] read in flight
            ST_CHK1: begin
                first_raddr = r_top.node;
                n_state     = (best_rdata < r_top.key) ? ST_POP0 : ST_CHK2;
            end
            ST_CHK2: begin
                n_e     = first_rdata;
                n_state = ST_ED0;
            end
            ST_ED0: begin
                n_state = (r_e == NO_EDGE) ? ST_POP0 : ST_ED1;
            end
            ST_ED1: begin
                n_edge     = edge_rdata;
                best_raddr = edge_rdata.target;
                n_state    = ST_ED2;
            end
            ST_ED2: begin
                n_e     = r_edge.link;
                n_newd  = relax_sum[DIST_BITS-1:0];
                n_state = ST_ED0;
                if (relax_sum < {1'b0, INF_DIST} &&
                    relax_sum[DIST_BITS-1:0] < best_rdata) begin
                    best_we    = 1'b1;
                    best_waddr = r_edge.target;
                    best_wdata = relax_sum[DIST_BITS-1:0];
                    if (r_fill != HEAP_BITS'(HEAP_CAP)) begin
                        n_hi    = r_fill;
                        n_fill  = r_fill + 1'b1;
                        n_state = ST_PU0;
                    end
                end
            end
            ST_PU0: begin
                if (r_hi == '0) begin
                    heap_we    = 1'b1;
                    heap_wdata = '{key: r_newd, node: r_edge.target};
                    n_state    = ST_ED0;
                end else begin
                    heap_raddr = (r_hi - 1'b1) >> 1;
                    n_hc       = (r_hi - 1'b1) >> 1;
                    n_state    = ST_PU1;
                end
            end
            ST_PU1: begin
                heap_we = 1'b1;
                if (heap_rdata.key <= r_newd) begin
                    heap_wdata = '{key: r_newd, node: r_edge.target};
                    n_state    = ST_ED0;
                end else begin
                    heap_wdata = heap_rdata;
                    n_hi       = r_hc;
                    n_state    = ST_PU0;
                end
            end
            ST_SUM: begin
                // read one node a cycle, score it the cycle after
                best_raddr = r_idx[NODE_BITS-1:0];
                if (sum_issue) begin
                    n_pv   = 1'b1;
                    n_pidx = r_idx[NODE_BITS-1:0];
                    n_idx  = r_idx + 1'b1;
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv && r_pidx != r_start && best_rdata < INF_DIST) begin
                    n_cnt = r_cnt + 1'b1;
                    if (best_rdata > r_max) begin
                        n_max = best_rdata;
                    end
                end
                if (!sum_issue && !r_pv && (!r_ovalid || o_out.ready)) begin
                    n_ovalid = 1'b1;
                    n_ocnt   = r_cnt;
                    n_omax   = r_max[OUT_DBITS-1:0];
                    n_odrop  = r_ovf;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_FCLR;
            r_idx    <= '0;
            r_stored <= '0;
            r_ovf    <= 1'b0;
            r_ncount <= NODE_BITS'(1);
            r_fill   <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_stored <= n_stored;
            r_ovf    <= n_ovf;
            r_fill   <= n_fill;
            r_pv     <= n_pv;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_ncount <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;  r_src  <= n_src;   r_dst  <= n_dst;   r_w     <= n_w;
        r_top   <= n_top;    r_last <= n_last;  r_child <= n_child;
        r_hi    <= n_hi;     r_hc   <= n_hc;    r_e    <= n_e;     r_edge  <= n_edge;
        r_newd  <= n_newd;   r_pidx <= n_pidx;  r_cnt  <= n_cnt;   r_max   <= n_max;
        r_ocnt  <= n_ocnt;   r_omax <= n_omax;  r_odrop <= n_odrop;
    end

    // heap never grows past its capacity, edge count never past the store
    `SPR_ASSERT_NOW(a_heap_cap, i_clk, i_rst_n, 1'b1, r_fill <= HEAP_BITS'(HEAP_CAP))
    `SPR_ASSERT_NOW(a_edge_cap, i_clk, i_rst_n, 1'b1, r_stored <= EPTR_BITS'(MAX_EDGES))
    // a run word always starts with the distance sweep
    `SPR_ASSERT_NEXT(a_run_sweep, i_clk, i_rst_n, run_acc, r_state == ST_DCLR)
endmodule
